@@ rtl/core/mbox_body_from_quoter_defines.svh @@
// ----------------------------------------------------------------------------
// mbox_body_from_quoter assertion macros
// Shared concurrent assertion wrappers for the "From " quoting block.
// ----------------------------------------------------------------------------
`ifndef MBOX_BODY_FROM_QUOTER_DEFINES_SVH
`define MBOX_BODY_FROM_QUOTER_DEFINES_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define MBFQ_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// when ante holds, cons must hold in the next clock cycle
`define MBFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MBFQ_ASSERT(lbl, clk, rst_n, expr, msg)
`define MBFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/mbfq_pkg.sv @@
// ----------------------------------------------------------------------------
// mbfq_pkg
// Types and character constants for the mailbox "From " line quoter.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfq_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h3E;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // output slots of one command, in emission order
    localparam int NUM_HELD  = 4;
    localparam int NUM_SLOTS = 7;
    localparam int SLOT_QUOTE = 0;
    localparam int SLOT_HELD0 = 1;
    localparam int SLOT_BYTE  = 5;
    localparam int SLOT_NL    = 6;

    // one decoded input item: what the back end has to emit
    typedef struct packed {
        logic                 quote;
        logic [2:0]           held_cnt;
        logic [3:0][7:0]      held;
        logic                 has_byte;
        logic [7:0]           data;
        logic                 nl;
    } t_cmd;

    // lower-case letters of the keyword, by match position
    function automatic logic [7:0] word_letter(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h66;
            2'd1:    c = 8'h72;
            2'd2:    c = 8'h6F;
            default: c = 8'h6D;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mbfq_front.sv @@
// ----------------------------------------------------------------------------
// mbfq_front
// Line-start tracking and "From " matching; turns input bytes into commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mbox_body_from_quoter_defines.svh"

module mbfq_front
    import mbfq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_tvalid,
    output logic            o_tready,
    input  wire logic [7:0] i_tdata,    // body_byte
    input  wire logic       i_tuser,    // byte_present
    input  wire logic       i_tlast,    // body_end
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_MATCH = 2'd1,
        PH_MID   = 2'd2
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [2:0]      r_pos, n_pos;
    logic [3:0][7:0] r_held, n_held;
    logic            accept;
    logic            is_nl, is_ws;
    logic [7:0]      lower;
    t_cmd            cmd;

    assign accept   = i_tvalid && !i_q_full;
    assign o_tready = !i_q_full;
    assign is_nl    = (i_tdata == CH_NL);
    assign is_ws    = (i_tdata == CH_SP) || (i_tdata == CH_TAB);
    assign lower    = i_tdata | CASE_BIT;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_held       = r_held;
        cmd          = '0;
        cmd.data     = i_tdata;

        if (i_tuser) begin
            unique case (r_phase)
                PH_START: begin
                    if (i_tdata == CH_QUOTE) begin
                        cmd.has_byte = 1'b1;
                    end else if (lower == word_letter(2'd0)) begin
                        n_held[0] = i_tdata;
                        n_pos     = 3'd1;
                        n_phase   = PH_MATCH;
                    end else begin
                        cmd.has_byte = 1'b1;
                        n_phase      = is_nl ? PH_START : PH_MID;
                    end
                end
                PH_MATCH: begin
                    if (r_pos < 3'd4 && lower == word_letter(r_pos[1:0])) begin
                        n_held[r_pos[1:0]] = i_tdata;
                        n_pos              = r_pos + 3'd1;
                    end else if (r_pos >= 3'd4 && is_ws) begin
                        // full match: extra quote, held letters, then the blank
                        cmd.quote    = 1'b1;
                        cmd.held_cnt = r_pos;
                        cmd.has_byte = 1'b1;
                        n_pos        = 3'd0;
                        n_phase      = PH_MID;
                    end else begin
                        cmd.held_cnt = r_pos;
                        cmd.has_byte = 1'b1;
                        n_pos        = 3'd0;
                        n_phase      = is_nl ? PH_START : PH_MID;
                    end
                end
                default: begin
                    cmd.has_byte = 1'b1;
                    if (is_nl) begin
                        n_phase = PH_START;
                    end
                end
            endcase
        end

        if (i_tlast) begin
            // flush whatever is still held, then close the body
            if (n_phase == PH_MATCH) begin
                cmd.held_cnt = n_pos;
            end
            cmd.nl  = 1'b1;
            n_phase = PH_START;
            n_pos   = 3'd0;
        end

        cmd.held = n_held;
    end

    assign o_cmd  = cmd;
    assign o_push = accept &&
                    (cmd.quote || cmd.held_cnt != 3'd0 || cmd.has_byte || cmd.nl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_pos   <= 3'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    `MBFQ_ASSERT(a_match_has_letters, i_clk, i_rst_n,
        (r_phase != PH_MATCH) || (r_pos >= 3'd1 && r_pos <= 3'd4),
        "front: matching phase without held letters")
    `MBFQ_ASSERT(a_idle_holds_nothing, i_clk, i_rst_n,
        (r_phase == PH_MATCH) || (r_pos == 3'd0),
        "front: letters held outside matching phase")

endmodule

`default_nettype wire

@@ rtl/core/mbfq_queue.sv @@
// ----------------------------------------------------------------------------
// mbfq_queue
// Short command FIFO between the matcher and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mbox_body_from_quoter_defines.svh"

module mbfq_queue
    import mbfq_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `MBFQ_ASSERT(a_no_push_when_full, i_clk, i_rst_n,
        !(i_push && o_full),
        "queue: push while full")

endmodule

`default_nettype wire

@@ rtl/core/mbfq_back.sv @@
// ----------------------------------------------------------------------------
// mbfq_back
// Serializes one command into output bytes, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mbox_body_from_quoter_defines.svh"

module mbfq_back
    import mbfq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_cmd       i_q_cmd,
    output logic            o_q_pop,
    output logic            o_tvalid,
    input  wire logic       i_tready,
    output logic [7:0]      o_tdata,    // out_byte
    output logic            o_tlast,    // run_last
    output logic            o_tuser     // message_done
);

    t_cmd                 r_cur;
    logic                 r_cur_valid;
    logic [NUM_SLOTS-1:0] r_rem;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;
    logic                 r_out_done;

    logic [NUM_SLOTS-1:0] low, rest, load_mask;
    logic [7:0]           slot_byte;
    logic                 can_out, emit, last, load, pop;

    always_comb begin
        load_mask             = '0;
        load_mask[SLOT_QUOTE] = i_q_cmd.quote;
        for (int i = 0; i < NUM_HELD; i++) begin
            load_mask[SLOT_HELD0 + i] = (3'(i) < i_q_cmd.held_cnt);
        end
        load_mask[SLOT_BYTE]  = i_q_cmd.has_byte;
        load_mask[SLOT_NL]    = i_q_cmd.nl;
    end

    // lowest pending slot goes out next
    assign low  = r_rem & (~r_rem + 1'b1);
    assign rest = r_rem & ~low;

    always_comb begin
        slot_byte = '0;
        if (low[SLOT_QUOTE]) begin
            slot_byte = slot_byte | CH_QUOTE;
        end
        for (int i = 0; i < NUM_HELD; i++) begin
            if (low[SLOT_HELD0 + i]) begin
                slot_byte = slot_byte | r_cur.held[i];
            end
        end
        if (low[SLOT_BYTE]) begin
            slot_byte = slot_byte | r_cur.data;
        end
        if (low[SLOT_NL]) begin
            slot_byte = slot_byte | CH_NL;
        end
    end

    assign can_out = !r_out_valid || i_tready;
    assign emit    = can_out && r_cur_valid;
    assign last    = (rest == '0);
    assign load    = !r_cur_valid || (emit && last);
    assign pop     = load && i_q_valid;
    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end

            if (pop) begin
                r_cur_valid <= 1'b1;
                r_rem       <= load_mask;
            end else if (emit) begin
                r_cur_valid <= !last;
                r_rem       <= rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_q_cmd;
        end
        if (emit) begin
            r_out_byte <= slot_byte;
            r_out_last <= last;
            r_out_done <= low[SLOT_NL];
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;
    assign o_tuser  = r_out_done;

    `MBFQ_ASSERT(a_busy_has_work, i_clk, i_rst_n,
        !r_cur_valid || (r_rem != '0),
        "back: active command with no bytes left")
    `MBFQ_ASSERT_NEXT(a_emit_shows_beat, i_clk, i_rst_n,
        emit, r_out_valid,
        "back: emitted beat not presented")

endmodule

`default_nettype wire

@@ rtl/core/mbox_body_from_quoter.sv @@
// A byte passes the queue, serializer and output registers. Throughput: one
// output beat per cycle while m_axis_tready is high; one input byte per cycle
// while each byte yields at most one beat. A byte with more beats holds the
// serializer until done; the queue absorbs short bursts, then the input stalls.
// Reset (synchronous, active low) returns to line start and empties all stages.
// ----------------------------------------------------------------------------
// mbox_body_from_quoter
// Copies a body, adding one '>' to lines starting >*From and a space or tab.
// ----------------------------------------------------------------------------
`default_nettype none

module mbox_body_from_quoter
    import mbfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] body_byte
    input  wire logic       s_axis_tuser,   // [0] byte_present
    input  wire logic       s_axis_tlast,   // body_end
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tuser,   // [0] message_done
    output logic            m_axis_tlast    // run_last
);

    logic q_full, q_valid, push, pop;
    t_cmd push_cmd, head_cmd;

    mbfq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_tlast  (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    mbfq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    mbfq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast),
        .o_tuser   (m_axis_tuser)
    );

endmodule

`default_nettype wire
